// ----- hw/rtl/svd_pkg.sv -----
package svd_pkg;

    // Result codes
    typedef logic [2:0] sector_t;

    localparam sector_t SECT_0      = 3'd0;
    localparam sector_t SECT_1      = 3'd1;
    localparam sector_t SECT_2      = 3'd2;
    localparam sector_t SECT_3      = 3'd3;
    localparam sector_t SECT_4      = 3'd4;
    localparam sector_t SECT_5      = 3'd5;
    localparam sector_t SECTOR_ZERO = 3'd6;

    // Which of the three placed edges a phase takes
    typedef logic [1:0] rank_t;

    localparam rank_t RANK_BASE = 2'd0;
    localparam rank_t RANK_MID  = 2'd1;
    localparam rank_t RANK_LAST = 2'd2;

    typedef struct packed {
        rank_t a;
        rank_t b;
        rank_t c;
    } ranks_t;

    // Control that travels with each beat through the pipe
    typedef struct packed {
        logic valid;
        logic zero;
        logic high_first;
    } ctl_t;

    // Q16 constants, rounded to nearest
    localparam logic signed [18:0] Q_INV_SQRT3 = 19'sd37837;
    localparam logic signed [18:0] Q_SQRT3     = 19'sd113512;
    localparam logic signed [18:0] Q_SQRT3_2   = 19'sd56756;
    localparam logic signed [18:0] Q_ONE_HALF3 = 19'sd98304;
    localparam int               Q_SHIFT     = 16;

    // Growth of products and of the duty sums over the input width
    localparam int PROD_GROW = 19;
    localparam int SUM_GROW  = 21;

    localparam logic [15:0] DUTY_HALF = 16'd16384;
    localparam logic [15:0] DUTY_ONE  = 16'd32768;

    // Accept edge to result edge
    localparam int PIPE_LAT = 5;

endpackage

// ----- hw/rtl/svd_front.sv -----
module svd_front #(
    parameter int VOLT_WIDTH = 16
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              in_valid,
    input  logic                                              high_first,
    input  logic signed [VOLT_WIDTH-1:0]                      alpha,
    input  logic signed [VOLT_WIDTH-1:0]                      beta,
    output svd_pkg::ctl_t                                     ctl,
    output svd_pkg::sector_t                                  sector,
    output logic signed [VOLT_WIDTH+svd_pkg::PROD_GROW-1:0]   x_val,
    output logic signed [VOLT_WIDTH+svd_pkg::PROD_GROW-1:0]   y_val,
    output logic signed [VOLT_WIDTH+svd_pkg::PROD_GROW-1:0]   z_val
);
    import svd_pkg::*;

    localparam int PW = VOLT_WIDTH + PROD_GROW;

    logic signed [PW-1:0] a_ext;
    logic signed [PW-1:0] b_ext;

    // stage 1: constant products
    ctl_t                 s1_ctl_reg;
    ctl_t                 s1_ctl_next;
    logic signed [PW-1:0] s1_as_reg;
    logic signed [PW-1:0] s1_bk_reg;
    logic signed [PW-1:0] s1_bx_reg;
    logic signed [PW-1:0] s1_ay_reg;
    logic signed [PW-1:0] s1_bh_reg;

    // stage 2: sector and X/Y/Z
    ctl_t                 s2_ctl_reg;
    sector_t              s2_sector_reg;
    sector_t              s2_sector_next;
    logic signed [PW-1:0] s2_x_reg;
    logic signed [PW-1:0] s2_y_reg;
    logic signed [PW-1:0] s2_z_reg;

    logic a_neg;
    logic b_neg;
    logic bk_gt;
    logic nbk_gt;

    assign a_ext = PW'(alpha);
    assign b_ext = PW'(beta);

    always_comb
    begin
        s1_ctl_next.valid      = in_valid;
        s1_ctl_next.zero       = (alpha == '0) && (beta == '0);
        s1_ctl_next.high_first = high_first;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
        end
        else
        begin
            s1_ctl_reg <= s1_ctl_next;
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_as_reg <= a_ext <<< Q_SHIFT;
        s1_bk_reg <= b_ext * PW'(Q_INV_SQRT3);
        s1_bx_reg <= b_ext * PW'(Q_SQRT3);
        s1_ay_reg <= a_ext * PW'(Q_ONE_HALF3);
        s1_bh_reg <= b_ext * PW'(Q_SQRT3_2);
    end

    // signs survive the positive scale factors
    assign a_neg  = s1_as_reg[PW-1];
    assign b_neg  = s1_bk_reg[PW-1];
    assign bk_gt  = s1_bk_reg > s1_as_reg;
    assign nbk_gt = (-s1_bk_reg) > s1_as_reg;

    always_comb
    begin
        if (!b_neg)
        begin
            if (!a_neg) s2_sector_next = bk_gt  ? SECT_1 : SECT_0;
            else        s2_sector_next = nbk_gt ? SECT_2 : SECT_1;
        end
        else
        begin
            if (!a_neg) s2_sector_next = nbk_gt ? SECT_4 : SECT_5;
            else        s2_sector_next = bk_gt  ? SECT_3 : SECT_4;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_sector_reg <= s2_sector_next;
        s2_x_reg      <= s1_bx_reg;
        s2_y_reg      <= s1_bh_reg + s1_ay_reg;
        s2_z_reg      <= s1_bh_reg - s1_ay_reg;
    end

    assign ctl    = s2_ctl_reg;
    assign sector = s2_sector_reg;
    assign x_val  = s2_x_reg;
    assign y_val  = s2_y_reg;
    assign z_val  = s2_z_reg;

endmodule

// ----- hw/rtl/svd_place.sv -----
module svd_place #(
    parameter int VOLT_WIDTH = 16
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  svd_pkg::ctl_t                                     ctl_in,
    input  svd_pkg::sector_t                                  sector_in,
    input  logic signed [VOLT_WIDTH+svd_pkg::PROD_GROW-1:0]   x_val,
    input  logic signed [VOLT_WIDTH+svd_pkg::PROD_GROW-1:0]   y_val,
    input  logic signed [VOLT_WIDTH+svd_pkg::PROD_GROW-1:0]   z_val,
    output svd_pkg::ctl_t                                     ctl_out,
    output svd_pkg::sector_t                                  sector_out,
    output svd_pkg::ranks_t                                   ranks,
    output logic signed [VOLT_WIDTH+svd_pkg::SUM_GROW-1:0]    t_base,
    output logic signed [VOLT_WIDTH+svd_pkg::SUM_GROW-1:0]    t_mid,
    output logic signed [VOLT_WIDTH+svd_pkg::SUM_GROW-1:0]    t_last
);
    import svd_pkg::*;

    localparam int PW = VOLT_WIDTH + PROD_GROW;
    localparam int SW = VOLT_WIDTH + SUM_GROW;
    localparam logic signed [SW-1:0] ONE = SW'(1) <<< (VOLT_WIDTH + 14);

    // stage 3: on-time select and phase order
    ctl_t                 s3_ctl_reg;
    sector_t              s3_sector_reg;
    ranks_t               s3_ranks_reg;
    ranks_t               s3_ranks_next;
    logic signed [PW-1:0] s3_d1_reg;
    logic signed [PW-1:0] s3_d1_next;
    logic signed [PW-1:0] s3_d2_reg;
    logic signed [PW-1:0] s3_d2_next;

    // stage 4: the base, mid and last on-time sums
    ctl_t                 s4_ctl_reg;
    sector_t              s4_sector_reg;
    ranks_t               s4_ranks_reg;
    logic signed [SW-1:0] s4_base_reg;
    logic signed [SW-1:0] s4_mid_reg;
    logic signed [SW-1:0] s4_last_reg;

    logic signed [SW-1:0] d1_ext;
    logic signed [SW-1:0] d2_ext;
    logic                 hf;

    assign hf = ctl_in.high_first;

    always_comb
    begin
        s3_d1_next    = '0;
        s3_d2_next    = '0;
        s3_ranks_next = '{a: RANK_BASE, b: RANK_BASE, c: RANK_BASE};
        unique case (sector_in)
            SECT_0:
            begin
                if (hf)
                begin
                    s3_d1_next = x_val;  s3_d2_next = -z_val;
                    s3_ranks_next = '{a: RANK_LAST, b: RANK_MID, c: RANK_BASE};
                end
                else
                begin
                    s3_d1_next = -z_val; s3_d2_next = x_val;
                    s3_ranks_next = '{a: RANK_BASE, b: RANK_MID, c: RANK_LAST};
                end
            end
            SECT_1:
            begin
                if (hf)
                begin
                    s3_d1_next = y_val;  s3_d2_next = z_val;
                    s3_ranks_next = '{a: RANK_MID, b: RANK_LAST, c: RANK_BASE};
                end
                else
                begin
                    s3_d1_next = z_val;  s3_d2_next = y_val;
                    s3_ranks_next = '{a: RANK_MID, b: RANK_BASE, c: RANK_LAST};
                end
            end
            SECT_2:
            begin
                if (hf)
                begin
                    s3_d1_next = -y_val; s3_d2_next = x_val;
                    s3_ranks_next = '{a: RANK_BASE, b: RANK_LAST, c: RANK_MID};
                end
                else
                begin
                    s3_d1_next = x_val;  s3_d2_next = -y_val;
                    s3_ranks_next = '{a: RANK_LAST, b: RANK_BASE, c: RANK_MID};
                end
            end
            SECT_3:
            begin
                if (hf)
                begin
                    s3_d1_next = z_val;  s3_d2_next = -x_val;
                    s3_ranks_next = '{a: RANK_BASE, b: RANK_MID, c: RANK_LAST};
                end
                else
                begin
                    s3_d1_next = -x_val; s3_d2_next = z_val;
                    s3_ranks_next = '{a: RANK_LAST, b: RANK_MID, c: RANK_BASE};
                end
            end
            SECT_4:
            begin
                if (hf)
                begin
                    s3_d1_next = -z_val; s3_d2_next = -y_val;
                    s3_ranks_next = '{a: RANK_MID, b: RANK_BASE, c: RANK_LAST};
                end
                else
                begin
                    s3_d1_next = -y_val; s3_d2_next = -z_val;
                    s3_ranks_next = '{a: RANK_MID, b: RANK_LAST, c: RANK_BASE};
                end
            end
            SECT_5:
            begin
                if (hf)
                begin
                    s3_d1_next = -x_val; s3_d2_next = y_val;
                    s3_ranks_next = '{a: RANK_LAST, b: RANK_BASE, c: RANK_MID};
                end
                else
                begin
                    s3_d1_next = y_val;  s3_d2_next = -x_val;
                    s3_ranks_next = '{a: RANK_BASE, b: RANK_LAST, c: RANK_MID};
                end
            end
            default:
            begin
                s3_d1_next    = '0;
                s3_d2_next    = '0;
                s3_ranks_next = '{a: RANK_BASE, b: RANK_BASE, c: RANK_BASE};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
        end
        else
        begin
            s3_ctl_reg <= ctl_in;
            s4_ctl_reg <= s3_ctl_reg;
        end
    end

    assign d1_ext = SW'(s3_d1_reg);
    assign d2_ext = SW'(s3_d2_reg);

    // base, base + 2*d1, base + 2*d1 + 2*d2 with base = one - d1 - d2
    always_ff @(posedge clk)
    begin
        s3_sector_reg <= sector_in;
        s3_ranks_reg  <= s3_ranks_next;
        s3_d1_reg     <= s3_d1_next;
        s3_d2_reg     <= s3_d2_next;

        s4_sector_reg <= s3_sector_reg;
        s4_ranks_reg  <= s3_ranks_reg;
        s4_base_reg   <= ONE - d1_ext - d2_ext;
        s4_mid_reg    <= ONE + d1_ext - d2_ext;
        s4_last_reg   <= ONE + d1_ext + d2_ext;
    end

    assign ctl_out    = s4_ctl_reg;
    assign sector_out = s4_sector_reg;
    assign ranks      = s4_ranks_reg;
    assign t_base     = s4_base_reg;
    assign t_mid      = s4_mid_reg;
    assign t_last     = s4_last_reg;

endmodule

// ----- hw/rtl/svd_sat.sv -----
module svd_sat #(
    parameter int VOLT_WIDTH = 16
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  svd_pkg::ctl_t                                     ctl_in,
    input  svd_pkg::sector_t                                  sector_in,
    input  svd_pkg::ranks_t                                   ranks,
    input  logic signed [VOLT_WIDTH+svd_pkg::SUM_GROW-1:0]    t_base,
    input  logic signed [VOLT_WIDTH+svd_pkg::SUM_GROW-1:0]    t_mid,
    input  logic signed [VOLT_WIDTH+svd_pkg::SUM_GROW-1:0]    t_last,
    output logic                                              done,
    output logic [15:0]                                       duty_a,
    output logic [15:0]                                       duty_b,
    output logic [15:0]                                       duty_c,
    output svd_pkg::sector_t                                  sector_code
);
    import svd_pkg::*;

    localparam int SW = VOLT_WIDTH + SUM_GROW;
    localparam logic signed [SW-1:0] TWO  = SW'(1) <<< (VOLT_WIDTH + 15);
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (VOLT_WIDTH - 1);

    logic        done_reg;
    logic [15:0] duty_a_reg;
    logic [15:0] duty_b_reg;
    logic [15:0] duty_c_reg;
    sector_t     sector_reg;

    logic [15:0] q_base;
    logic [15:0] q_mid;
    logic [15:0] q_last;

    // clamp to [0, 2.0], round half up, drop to Q1.15
    function automatic logic [15:0] to_q15(input logic signed [SW-1:0] tw);
        logic signed [SW-1:0] c;
        logic        [SW-1:0] u;
        if (tw < 0)
            c = '0;
        else if (tw > TWO)
            c = TWO;
        else
            c = tw;
        u = unsigned'(c) + unsigned'(HALF);
        return u[VOLT_WIDTH+15:VOLT_WIDTH];
    endfunction

    function automatic logic [15:0] pick(input rank_t r, input logic [15:0] b,
                                         input logic [15:0] m, input logic [15:0] l);
        logic [15:0] v;
        case (r)
            RANK_BASE: v = b;
            RANK_MID:  v = m;
            RANK_LAST: v = l;
            default:   v = b;
        endcase
        return v;
    endfunction

    assign q_base = to_q15(t_base);
    assign q_mid  = to_q15(t_mid);
    assign q_last = to_q15(t_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctl_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.zero)
        begin
            duty_a_reg <= DUTY_HALF;
            duty_b_reg <= DUTY_HALF;
            duty_c_reg <= DUTY_HALF;
            sector_reg <= SECTOR_ZERO;
        end
        else
        begin
            duty_a_reg <= pick(ranks.a, q_base, q_mid, q_last);
            duty_b_reg <= pick(ranks.b, q_base, q_mid, q_last);
            duty_c_reg <= pick(ranks.c, q_base, q_mid, q_last);
            sector_reg <= sector_in;
        end
    end

    assign done        = done_reg;
    assign duty_a      = duty_a_reg;
    assign duty_b      = duty_b_reg;
    assign duty_c      = duty_c_reg;
    assign sector_code = sector_reg;

endmodule

// ----- hw/rtl/svpwm_sector_duty_top.sv -----
// Space vector PWM sector and duty unit. Give it an alpha/beta voltage
// vector (signed, VOLT_WIDTH-2 fraction bits, normalized to the bus) with a
// one-cycle start pulse and, once it has passed the pipeline, done pulses for one
// cycle with the three phase duties (unsigned Q1.15, 32768 = 1.0, saturated
// to 0..1) and the sector 0..5; a vector of exactly zero gives 0.5 on every
// phase and sector code 6. The datapath is a five-stage pipeline that takes
// a new beat on every clock, so busy never rises and start may be held high
// continuously; the result has no back-pressure, so the receiver must take
// each beat in the cycle done is high. cfg_wr_data written with cfg_wr_en
// selects high-first (1) or low-first (0) vector order; write it only while
// no beat is in flight.
module svpwm_sector_duty_top #(
    parameter int VOLT_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,

    // configuration
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,

    // command side
    input  logic                         start,
    output logic                         busy,
    input  logic signed [VOLT_WIDTH-1:0] alpha_volts,
    input  logic signed [VOLT_WIDTH-1:0] beta_volts,

    // result side
    output logic                         done,
    output logic [15:0]                  duty_a,
    output logic [15:0]                  duty_b,
    output logic [15:0]                  duty_c,
    output logic [2:0]                   sector_code
);
    import svd_pkg::*;

    localparam int PW = VOLT_WIDTH + PROD_GROW;
    localparam int SW = VOLT_WIDTH + SUM_GROW;

    logic high_first_order_reg;
    logic accept;

    ctl_t                 front_ctl;
    sector_t              front_sector;
    logic signed [PW-1:0] x_val;
    logic signed [PW-1:0] y_val;
    logic signed [PW-1:0] z_val;

    ctl_t                 place_ctl;
    sector_t              place_sector;
    ranks_t               place_ranks;
    logic signed [SW-1:0] t_base;
    logic signed [SW-1:0] t_mid;
    logic signed [SW-1:0] t_last;

    // Fully pipelined, no stall source: always ready for a beat.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            high_first_order_reg <= 1'b0;
        else if (cfg_wr_en)
            high_first_order_reg <= cfg_wr_data;
    end

    // Stages 1-2: constant products, then sector and X/Y/Z.
    svd_front #(
        .VOLT_WIDTH (VOLT_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .high_first (high_first_order_reg),
        .alpha      (alpha_volts),
        .beta       (beta_volts),
        .ctl        (front_ctl),
        .sector     (front_sector),
        .x_val      (x_val),
        .y_val      (y_val),
        .z_val      (z_val)
    );

    // Stages 3-4: on-time and phase-order select, then the base, mid and last sums.
    svd_place #(
        .VOLT_WIDTH (VOLT_WIDTH)
    ) u_place (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl_in     (front_ctl),
        .sector_in  (front_sector),
        .x_val      (x_val),
        .y_val      (y_val),
        .z_val      (z_val),
        .ctl_out    (place_ctl),
        .sector_out (place_sector),
        .ranks      (place_ranks),
        .t_base     (t_base),
        .t_mid      (t_mid),
        .t_last     (t_last)
    );

    // Stage 5: saturate, round, map to phases, zero-vector override.
    svd_sat #(
        .VOLT_WIDTH (VOLT_WIDTH)
    ) u_sat (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl_in      (place_ctl),
        .sector_in   (place_sector),
        .ranks       (place_ranks),
        .t_base      (t_base),
        .t_mid       (t_mid),
        .t_last      (t_last),
        .done        (done),
        .duty_a      (duty_a),
        .duty_b      (duty_b),
        .duty_c      (duty_c),
        .sector_code (sector_code)
    );

    // Every accepted beat comes out after the fixed latency, and nothing else does.
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##PIPE_LAT done)
        else $error("accepted beat did not complete on time");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, PIPE_LAT))
        else $error("result beat without a matching accept");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (duty_a <= DUTY_ONE) && (duty_b <= DUTY_ONE) && (duty_c <= DUTY_ONE)
                 && (sector_code <= SECTOR_ZERO))
        else $error("duty or sector out of range");

    a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (sector_code == SECTOR_ZERO)) |->
            (duty_a == DUTY_HALF) && (duty_b == DUTY_HALF) && (duty_c == DUTY_HALF))
        else $error("zero vector without centered duties");

endmodule

// ----- tb/svpwm_sector_duty_top_test.sv -----
`timescale 1ns / 100ps

module svpwm_sector_duty_top_test;

    import svd_pkg::*;

    // Q16 gains of the duty math and the unit duty at product scale (2^30)
    localparam longint K_INV_SQRT3    = 37837;
    localparam longint K_SQRT3        = 113512;
    localparam longint K_SQRT3_2      = 56756;
    localparam longint K_ONE_HALF3    = 98304;
    localparam longint DUTY_SCALE_ONE = longint'(1) << 30;

    // Cycles with no beat on either side before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        sector_t     sector;
    } duties_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic               cfg_wr_data;
    logic               start;
    logic               busy;
    logic signed [15:0] alpha_volts;
    logic signed [15:0] beta_volts;
    logic               done;
    logic [15:0]        duty_a;
    logic [15:0]        duty_b;
    logic [15:0]        duty_c;
    logic [2:0]         sector_code;

    // Duties expected for accepted vectors, oldest first
    duties_t pending_duties[$];
    duties_t want;

    // Copy of the order register as the block should hold it
    logic    model_high_first;
    int      sender_idle_pct;
    int      mismatch_cnt;
    int      idle_cycles;

    svpwm_sector_duty_top #(
        .VOLT_WIDTH (16)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .start       (start),
        .busy        (busy),
        .alpha_volts (alpha_volts),
        .beta_volts  (beta_volts),
        .done        (done),
        .duty_a      (duty_a),
        .duty_b      (duty_b),
        .duty_c      (duty_c),
        .sector_code (sector_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Duty predictor
    // ------------------------------------------------------------------

    // Twice the duty at 2^30 scale -> saturated Q1.15, round half up
    function automatic logic [15:0] to_duty_q15(longint twice_duty);
        longint clipped;
        clipped = twice_duty;
        if (clipped < 0)
            clipped = 0;
        if (clipped > 2 * DUTY_SCALE_ONE)
            clipped = 2 * DUTY_SCALE_ONE;
        return 16'((clipped + (longint'(1) << 15)) >>> 16);
    endfunction

    function automatic duties_t svpwm_duties(logic signed [15:0] alpha,
                                             logic signed [15:0] beta,
                                             logic high_first);
        longint  a;
        longint  b;
        longint  alpha_q;
        longint  beta_k;
        longint  x;
        longint  y;
        longint  z;
        longint  ta;
        longint  tb;
        longint  d1;
        longint  d2;
        longint  base;
        longint  tw[3];
        int      p;
        int      q;
        int      r;
        int      swap;
        duties_t res;

        a = alpha;
        b = beta;
        if (a == 0 && b == 0)
        begin
            res.a      = DUTY_HALF;
            res.b      = DUTY_HALF;
            res.c      = DUTY_HALF;
            res.sector = SECTOR_ZERO;
            return res;
        end

        // Sector from quadrant and beta/sqrt3 against alpha
        alpha_q = a * 65536;
        beta_k  = b * K_INV_SQRT3;
        if (b >= 0)
            res.sector = (a >= 0) ? ((beta_k > alpha_q) ? SECT_1 : SECT_0)
                                  : ((-beta_k > alpha_q) ? SECT_2 : SECT_1);
        else
            res.sector = (a >= 0) ? ((-beta_k > alpha_q) ? SECT_4 : SECT_5)
                                  : ((beta_k > alpha_q) ? SECT_3 : SECT_4);

        x = K_SQRT3 * b;
        y = K_ONE_HALF3 * a + K_SQRT3_2 * b;
        z = -K_ONE_HALF3 * a + K_SQRT3_2 * b;

        // Low-first order: phase p takes the base, q adds ta, r adds tb
        case (res.sector)
            SECT_0: begin ta = -z; tb = x;  p = 0; q = 1; r = 2; end
            SECT_1: begin ta = z;  tb = y;  p = 1; q = 0; r = 2; end
            SECT_2: begin ta = x;  tb = -y; p = 1; q = 2; r = 0; end
            SECT_3: begin ta = -x; tb = z;  p = 2; q = 1; r = 0; end
            SECT_4: begin ta = -y; tb = -z; p = 2; q = 0; r = 1; end
            default:  begin ta = y;  tb = -x; p = 0; q = 2; r = 1; end
        endcase

        base = DUTY_SCALE_ONE - ta - tb;
        // High-first mirrors the sequence: ends swap, on-times swap
        if (high_first)
        begin
            d1   = tb;
            d2   = ta;
            swap = p;
            p    = r;
            r    = swap;
        end
        else
        begin
            d1 = ta;
            d2 = tb;
        end
        tw[p] = base;
        tw[q] = base + 2 * d1;
        tw[r] = tw[q] + 2 * d2;

        res.a = to_duty_q15(tw[0]);
        res.b = to_duty_q15(tw[1]);
        res.c = to_duty_q15(tw[2]);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every done beat pairs with the oldest expectation
    // ------------------------------------------------------------------

    task automatic check_field(string name, logic [15:0] expected, logic [15:0] actual);
        if (actual !== expected)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
            mismatch_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_duties.size() == 0)
            begin
                $error("duty beat with no vector pending: a=%0d b=%0d c=%0d sector=%0d",
                       duty_a, duty_b, duty_c, sector_code);
                mismatch_cnt++;
            end
            else
            begin
                want = pending_duties.pop_front();
                check_field("duty_a", want.a, duty_a);
                check_field("duty_b", want.b, duty_b);
                check_field("duty_c", want.c, duty_c);
                check_field("sector_code", 16'(want.sector), 16'(sector_code));
            end
        end
    end

    // Watchdog: any accepted vector or returned beat counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (start === 1'b1 && busy === 1'b0) || done === 1'b1)
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $error("no beat for %0d cycles, %0d results outstanding",
                   WATCHDOG_LIMIT, pending_duties.size());
            $display("[svpwm_sector_duty_top] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Drivers (inputs move on the falling edge)
    // ------------------------------------------------------------------

    // Present one vector, hold start until the block takes it, then
    // optionally idle. Start stays high into the next call when no idle
    // cycle is drawn, so back-to-back beats stream.
    task automatic send_vector(input logic signed [15:0] a, input logic signed [15:0] b);
        @(negedge clk);
        start       <= 1'b1;
        alpha_volts <= a;
        beta_volts  <= b;
        do @(posedge clk); while (busy !== 1'b0);
        pending_duties.push_back(svpwm_duties(a, b, model_high_first));
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            start       <= 1'b0;
            alpha_volts <= $urandom;
            beta_volts  <= $urandom;
        end
    endtask

    // Stop the stream and let the pipe empty out
    task automatic drain_pipe();
        @(negedge clk);
        start <= 1'b0;
        while (pending_duties.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 1) @(posedge clk);
    endtask

    // Order register only changes with nothing in flight
    task automatic write_order(input logic high_first);
        drain_pipe();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= high_first;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        model_high_first = high_first;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, axes, zero vector, sector centers and a sector edge
    task automatic test_directed_extremes();
        sender_idle_pct = 0;
        send_vector(0, 0);
        send_vector(32767, 0);
        send_vector(-32768, 0);
        send_vector(0, 32767);
        send_vector(0, -32768);
        send_vector(32767, 32767);
        send_vector(-32768, -32768);
        send_vector(32767, -32768);
        send_vector(-32768, 32767);
        send_vector(1, 0);
        send_vector(-1, 0);
        send_vector(0, 1);
        send_vector(0, -1);
        send_vector(-1, -1);
        // half-scale vectors at 30, 90, ... 330 degrees
        send_vector(7094, 4096);
        send_vector(0, 8192);
        send_vector(-7094, 4096);
        send_vector(-7094, -4096);
        send_vector(0, -8192);
        send_vector(7094, -4096);
        // 60 degrees, on the line between the first two sectors
        send_vector(4096, 7094);
    endtask

    task automatic test_high_first_centers();
        write_order(1'b1);
        sender_idle_pct = 0;
        send_vector(7094, 4096);
        send_vector(0, 8192);
        send_vector(-7094, 4096);
        send_vector(-7094, -4096);
        send_vector(0, -8192);
        send_vector(7094, -4096);
    endtask

    // Mix of full-range noise, scaled vectors, sector edges, axes and
    // near-zero vectors
    task automatic test_random_vectors(input int count, input int idle_pct);
        int kind;
        int lim;
        int ai;
        int bi;
        sender_idle_pct = idle_pct;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(9);
            if (kind <= 2)
            begin
                ai = $urandom;
                bi = $urandom;
            end
            else if (kind <= 5)
            begin
                lim = 1 << $urandom_range(1, 15);
                ai  = int'($urandom_range(0, 2 * lim)) - lim;
                bi  = int'($urandom_range(0, 2 * lim)) - lim;
            end
            else if (kind <= 7)
            begin
                // alpha within a few LSB of beta/sqrt3, either sign
                bi = int'($urandom_range(0, 32768)) - 16384;
                ai = int'((longint'(bi) * K_INV_SQRT3) >>> 16)
                     + int'($urandom_range(0, 4)) - 2;
                if ($urandom_range(1))
                    ai = -ai;
            end
            else if (kind == 8)
            begin
                ai = $urandom;
                bi = 0;
                if ($urandom_range(1))
                begin
                    bi = ai;
                    ai = 0;
                end
            end
            else
            begin
                ai = int'($urandom_range(0, 4)) - 2;
                bi = int'($urandom_range(0, 4)) - 2;
            end
            send_vector(16'(ai), 16'(bi));
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = 1'b0;
        start            = 1'b0;
        alpha_volts      = '0;
        beta_volts       = '0;
        model_high_first = 1'b0;
        sender_idle_pct  = 0;
        mismatch_cnt     = 0;
        idle_cycles      = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_order(1'b0);
        test_directed_extremes();
        test_high_first_centers();

        // random phases: streaming, sparse sender, streaming, then light gaps twice
        write_order(1'b0);
        test_random_vectors(200, 0);
        write_order(1'b1);
        test_random_vectors(200, 75);
        write_order(1'b0);
        test_random_vectors(100, 0);
        write_order(1'b1);
        test_random_vectors(200, 12);
        write_order(1'b0);
        test_random_vectors(80, 12);

        drain_pipe();
        repeat (PIPE_LAT + 2) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("[svpwm_sector_duty_top] OK");
        else
            $display("[svpwm_sector_duty_top] ERROR");
        $finish;
    end

endmodule
